@@ rtl/fcl_pkg.sv @@
package fcl_pkg;

    // word widths fixed by the interface
    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 12;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 6;
    localparam int OP_W      = 2;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    // layer size
    localparam int MAX_IN  = 64;
    localparam int MAX_OUT = 64;
    localparam int IN_AW   = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;

    // accumulator: full products plus growth over the columns plus bias headroom
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + IN_AW + 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_WEIGHT  = 2'd0;
    localparam logic [OP_W-1:0] OP_BIAS    = 2'd1;
    localparam logic [OP_W-1:0] OP_FEATURE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IN_FEATURES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_FEATURES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_BIAS     = 2'd2;

    typedef logic signed [ACC_W-1:0] t_acc;

    // feature token passed from cell to cell
    typedef struct packed {
        logic              vld;
        logic              first;
        logic [COL_W-1:0]  col;
        logic [DATA_W-1:0] feat;
    } t_tok;

endpackage

@@ rtl/fcl_ram.sv @@
module fcl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fcl_cell.sv @@
module fcl_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fcl_pkg::t_tok              i_tok,
    output fcl_pkg::t_tok              o_tok,
    input  logic                       i_w_we,
    input  logic                       i_b_we,
    input  logic [fcl_pkg::COL_W-1:0]  i_wr_col,
    input  logic [fcl_pkg::DATA_W-1:0] i_wr_data,
    input  logic                       i_use_bias,
    input  logic                       i_shift,
    input  fcl_pkg::t_acc              i_next_acc,
    output fcl_pkg::t_acc              o_acc
);

    fcl_pkg::t_tok                     r_tok;
    logic [fcl_pkg::DATA_W-1:0]        w_rdata;
    logic [fcl_pkg::DATA_W-1:0]        r_bias;
    logic signed [fcl_pkg::PROD_W-1:0] r_prod;
    logic                              r_pvld;
    logic                              r_pfirst;
    fcl_pkg::t_acc                     r_acc;
    fcl_pkg::t_acc                     n_acc;
    fcl_pkg::t_acc                     acc_base;

    // this row's weights, one word per column
    fcl_ram #(
        .WIDTH (fcl_pkg::DATA_W),
        .DEPTH (fcl_pkg::MAX_IN)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (i_w_we),
        .i_waddr (i_wr_col[fcl_pkg::IN_AW-1:0]),
        .i_wdata (i_wr_data),
        .i_raddr (i_tok.col[fcl_pkg::IN_AW-1:0]),
        .o_rdata (w_rdata)
    );

    // row bias
    always_ff @(posedge i_clk) begin
        if (i_b_we) begin
            r_bias <= i_wr_data;
        end
    end

    // token stage, lines up with the weight read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
        end
        r_tok.first <= i_tok.first;
        r_tok.col   <= i_tok.col;
        r_tok.feat  <= i_tok.feat;
    end

    assign o_tok = r_tok;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= r_tok.vld;
        end
        r_pfirst <= r_tok.first;
        r_prod   <= $signed(r_tok.feat) * $signed(w_rdata);
    end

    // accumulate, or shift toward the output end of the row
    always_comb begin
        acc_base = '0;
        if (i_use_bias) begin
            acc_base = fcl_pkg::ACC_W'($signed(r_bias)) <<< fcl_pkg::FRAC_BITS;
        end
        n_acc = r_acc;
        if (i_shift) begin
            n_acc = i_next_acc;
        end else if (r_pvld) begin
            n_acc = (r_pfirst ? acc_base : r_acc) + fcl_pkg::ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

@@ rtl/fully_connected_layer_forward.sv @@
// Dense layer: weight (operation 0), bias (operation 1) and feature (operation 2) words are
// written one per accepted word; the feature at column in_features-1 starts a pass that emits
// out_features results, row 0 first, with last on the final row. Values are signed Q4.12,
// sums round half up and saturate to 16 bits with a flag. A row of 64 cells, one per output
// row, each with its own weight memory and multiplier, holds the accumulators; the features
// stream through the row one column per cycle. A pass streams the in_features columns, waits
// for the stream to reach the last row in use, then shifts the results out of the row, row 0
// first, holding while the output is stalled. Input stall is high for the whole pass.
module fully_connected_layer_forward (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [fcl_pkg::OP_W-1:0]      i_operation,
    input  logic [fcl_pkg::ROW_W-1:0]     i_row,
    input  logic [fcl_pkg::COL_W-1:0]     i_column,
    input  logic signed [fcl_pkg::DATA_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fcl_pkg::ROW_W-1:0]     o_out_index,
    output logic signed [fcl_pkg::DATA_W-1:0] o_out_value,
    output logic                          o_saturated,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [fcl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fcl_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    localparam int RND_W = fcl_pkg::ACC_W - fcl_pkg::FRAC_BITS;

    logic [fcl_pkg::CNT_W-1:0] r_in_features;
    logic [fcl_pkg::CNT_W-1:0] r_out_features;
    logic                      r_use_bias;
    logic [fcl_pkg::CNT_W-1:0] nin;
    logic [fcl_pkg::CNT_W-1:0] nout;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [fcl_pkg::CNT_W-1:0] r_cnt;
    logic [fcl_pkg::CNT_W-1:0] n_cnt;

    logic                      in_acc;
    logic                      start;
    logic                      load;

    logic                       r_inj_vld;
    logic                       r_inj_first;
    logic [fcl_pkg::COL_W-1:0]  r_inj_col;
    logic [fcl_pkg::DATA_W-1:0] feat_rdata;

    fcl_pkg::t_tok tok [fcl_pkg::MAX_OUT+1];
    fcl_pkg::t_acc acc [fcl_pkg::MAX_OUT+1];

    fcl_pkg::t_acc              rnd_sum;
    logic signed [RND_W-1:0]    rnd_q;
    logic signed [fcl_pkg::DATA_W-1:0] sat_val;
    logic                       sat_flag;

    logic                              r_out_valid;
    logic [fcl_pkg::ROW_W-1:0]         r_out_index;
    logic signed [fcl_pkg::DATA_W-1:0] r_out_value;
    logic                              r_saturated;
    logic                              r_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_features  <= fcl_pkg::CNT_W'(64);
            r_out_features <= fcl_pkg::CNT_W'(64);
            r_use_bias     <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fcl_pkg::CFG_IN_FEATURES:  r_in_features  <= i_cfg_data;
                fcl_pkg::CFG_OUT_FEATURES: r_out_features <= i_cfg_data;
                fcl_pkg::CFG_USE_BIAS:     r_use_bias     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // counts in use, limited to the layer size, with zero taken as one
    always_comb begin
        nin = r_in_features;
        if (r_in_features == '0) begin
            nin = fcl_pkg::CNT_W'(1);
        end else if (r_in_features > fcl_pkg::CNT_W'(fcl_pkg::MAX_IN)) begin
            nin = fcl_pkg::CNT_W'(fcl_pkg::MAX_IN);
        end
        nout = r_out_features;
        if (r_out_features == '0) begin
            nout = fcl_pkg::CNT_W'(1);
        end else if (r_out_features > fcl_pkg::CNT_W'(fcl_pkg::MAX_OUT)) begin
            nout = fcl_pkg::CNT_W'(fcl_pkg::MAX_OUT);
        end
    end

    // input word handshake
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign start      = in_acc && (i_operation == fcl_pkg::OP_FEATURE)
                        && (fcl_pkg::CNT_W'(i_column) == nin - fcl_pkg::CNT_W'(1));
    assign load       = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // feature buffer, written by feature words and read during the sweep
    fcl_ram #(
        .WIDTH (fcl_pkg::DATA_W),
        .DEPTH (fcl_pkg::MAX_IN)
    ) u_features (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_operation == fcl_pkg::OP_FEATURE)),
        .i_waddr (i_column[fcl_pkg::IN_AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_cnt[fcl_pkg::IN_AW-1:0]),
        .o_rdata (feat_rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SWEEP;
                    n_cnt   = '0;
                end
            end
            S_SWEEP: begin
                n_cnt = r_cnt + fcl_pkg::CNT_W'(1);
                if (r_cnt == nin - fcl_pkg::CNT_W'(1)) begin
                    n_state = S_WAIT;
                    n_cnt   = '0;
                end
            end
            S_WAIT: begin
                n_cnt = r_cnt + fcl_pkg::CNT_W'(1);
                if (r_cnt == nout + fcl_pkg::CNT_W'(2)) begin
                    n_state = S_OUT;
                    n_cnt   = '0;
                end
            end
            S_OUT: begin
                if (load) begin
                    n_cnt = r_cnt + fcl_pkg::CNT_W'(1);
                    if (r_cnt == nout - fcl_pkg::CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // token injected at the head of the row, aligned with the buffer read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj_vld <= 1'b0;
        end else begin
            r_inj_vld <= (r_state == S_SWEEP);
        end
        r_inj_first <= (r_cnt == '0);
        r_inj_col   <= r_cnt[fcl_pkg::COL_W-1:0];
    end

    always_comb begin
        tok[0].vld   = r_inj_vld;
        tok[0].first = r_inj_first;
        tok[0].col   = r_inj_col;
        tok[0].feat  = feat_rdata;
    end

    assign acc[fcl_pkg::MAX_OUT] = '0;

    // row of cells, one per output row
    for (genvar g = 0; g < fcl_pkg::MAX_OUT; g++) begin : g_cell
        fcl_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (tok[g]),
            .o_tok      (tok[g+1]),
            .i_w_we     (in_acc && (i_operation == fcl_pkg::OP_WEIGHT)
                         && (i_row == fcl_pkg::ROW_W'(g))),
            .i_b_we     (in_acc && (i_operation == fcl_pkg::OP_BIAS)
                         && (i_row == fcl_pkg::ROW_W'(g))),
            .i_wr_col   (i_column),
            .i_wr_data  (i_value),
            .i_use_bias (r_use_bias),
            .i_shift    (load),
            .i_next_acc (acc[g+1]),
            .o_acc      (acc[g])
        );
    end

    // round half up and saturate the head accumulator
    always_comb begin
        rnd_sum  = acc[0] + (fcl_pkg::ACC_W'(1) <<< (fcl_pkg::FRAC_BITS - 1));
        rnd_q    = RND_W'(rnd_sum >>> fcl_pkg::FRAC_BITS);
        sat_flag = 1'b0;
        sat_val  = fcl_pkg::DATA_W'(rnd_q);
        if (rnd_q > RND_W'((2 ** (fcl_pkg::DATA_W - 1)) - 1)) begin
            sat_flag = 1'b1;
            sat_val  = fcl_pkg::DATA_W'((2 ** (fcl_pkg::DATA_W - 1)) - 1);
        end else if (rnd_q < -RND_W'(2 ** (fcl_pkg::DATA_W - 1))) begin
            sat_flag = 1'b1;
            sat_val  = {1'b1, {(fcl_pkg::DATA_W - 1){1'b0}}};
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (load) begin
            r_out_index <= r_cnt[fcl_pkg::ROW_W-1:0];
            r_out_value <= sat_val;
            r_saturated <= sat_flag;
            r_last      <= (r_cnt == nout - fcl_pkg::CNT_W'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_out_value = r_out_value;
    assign o_saturated = r_saturated;
    assign o_last      = r_last;

endmodule
